@@ rtl/core/oad_pkg.sv @@
// Shared types, codes and constants of the obstacle avoidance drive controller.
package oad_pkg;

   localparam int unsigned DIST_W   = 10;
   localparam int unsigned TICK_W   = 16;
   localparam int unsigned BUDGET_W = 32;
   localparam int unsigned DRIVE_W  = 13;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned CMD_W    = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [MODE_W-1:0] MODE_STOP     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STRAIGHT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_AVL1     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_AVL2     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_AVR1     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_AVR2     = 3'd5;
   localparam logic [MODE_W-1:0] MODE_TURNL    = 3'd6;
   localparam logic [MODE_W-1:0] MODE_TURNR    = 3'd7;

   localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_HALT     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STRAIGHT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DIST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEER_DIST   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVOID_TICKS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_TICKS  = 2'd3;

   localparam logic [DIST_W-1:0] STOP_DIST_RESET   = 10'd20;
   localparam logic [DIST_W-1:0] VEER_DIST_RESET   = 10'd40;
   localparam logic [TICK_W-1:0] AVOID_TICKS_RESET = 16'd700;
   localparam logic [TICK_W-1:0] TURN_TICKS_RESET  = 16'd1000;

   localparam logic signed [DRIVE_W-1:0] DRIVE_OFF      = 13'sd0;
   localparam logic signed [DRIVE_W-1:0] DRIVE_CRUISE   = 13'sd600;
   localparam logic signed [DRIVE_W-1:0] DRIVE_FAST     = 13'sd2000;
   localparam logic signed [DRIVE_W-1:0] DRIVE_BACK     = -13'sd500;
   localparam logic signed [DRIVE_W-1:0] DRIVE_BACK_HRD = -13'sd1500;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [CMD_W-1:0]    pending;
      logic [TICK_W-1:0]   phase;
      logic [BUDGET_W-1:0] budget;
   } oad_state_type;

   typedef struct packed {
      logic [DIST_W-1:0] stop_dist;
      logic [DIST_W-1:0] veer_dist;
      logic [TICK_W-1:0] avoid_ticks;
      logic [TICK_W-1:0] turn_ticks;
   } oad_cfg_type;

   function automatic logic signed [DRIVE_W-1:0] oad_left_drive(input logic [MODE_W-1:0] m);
      logic signed [DRIVE_W-1:0] d;
      case (m)
         MODE_STOP:     d = DRIVE_OFF;
         MODE_STRAIGHT: d = DRIVE_CRUISE;
         MODE_AVL1:     d = DRIVE_FAST;
         MODE_AVL2:     d = DRIVE_BACK;
         MODE_AVR1:     d = DRIVE_BACK;
         MODE_AVR2:     d = DRIVE_FAST;
         MODE_TURNL:    d = DRIVE_BACK_HRD;
         default:       d = DRIVE_FAST;
      endcase
      return d;
   endfunction

   function automatic logic signed [DRIVE_W-1:0] oad_right_drive(input logic [MODE_W-1:0] m);
      logic signed [DRIVE_W-1:0] d;
      case (m)
         MODE_STOP:     d = DRIVE_OFF;
         MODE_STRAIGHT: d = DRIVE_CRUISE;
         MODE_AVL1:     d = DRIVE_BACK;
         MODE_AVL2:     d = DRIVE_FAST;
         MODE_AVR1:     d = DRIVE_FAST;
         MODE_AVR2:     d = DRIVE_BACK;
         MODE_TURNL:    d = DRIVE_FAST;
         default:       d = DRIVE_BACK_HRD;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/core/oad_if.sv @@
// Request and response channel interfaces of the drive controller.
interface oad_req_if import oad_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic                load_budget;
   logic [BUDGET_W-1:0] budget_value;
   logic [DIST_W-1:0]   left_range;
   logic [DIST_W-1:0]   middle_range;

   modport source (output valid, command, load_budget, budget_value, left_range,
                   middle_range, input ready);
   modport sink (input valid, command, load_budget, budget_value, left_range,
                 middle_range, output ready);
endinterface

interface oad_rsp_if import oad_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] left_drive;
   logic signed [DRIVE_W-1:0] right_drive;
   logic [MODE_W-1:0]         mode;
   logic                      busy_res;

   modport source (output valid, left_drive, right_drive, mode, busy_res, input ready);
   modport sink (input valid, left_drive, right_drive, mode, busy_res, output ready);
endinterface

@@ rtl/core/oad_step.sv @@
// Next-state logic of the drive controller for one control tick.
module oad_step import oad_pkg::*; (
   input  oad_state_type       state,
   input  oad_cfg_type         cfg,
   input  logic [CMD_W-1:0]    command,
   input  logic                load_budget,
   input  logic [BUDGET_W-1:0] budget_value,
   input  logic [DIST_W-1:0]   left_range,
   input  logic [DIST_W-1:0]   middle_range,
   output oad_state_type       next_state,
   output logic                busy
);

   logic [CMD_W-1:0]    pend;
   logic [BUDGET_W-1:0] bud;
   logic [TICK_W-1:0]   limit;
   logic [MODE_W-1:0]   phase_next_mode;
   logic                valid_cmd;

   assign valid_cmd = (command == CMD_HALT) || (command == CMD_STRAIGHT) ||
                      (command == CMD_LEFT) || (command == CMD_RIGHT);
   assign pend = valid_cmd ? command : state.pending;
   assign bud  = load_budget ? budget_value : state.budget;

   always_comb begin
      case (state.mode)
         MODE_AVL1: begin
            limit = cfg.avoid_ticks;
            phase_next_mode = MODE_AVL2;
         end
         MODE_AVR1: begin
            limit = cfg.avoid_ticks;
            phase_next_mode = MODE_AVR2;
         end
         MODE_AVL2, MODE_AVR2: begin
            limit = cfg.avoid_ticks;
            phase_next_mode = MODE_STRAIGHT;
         end
         default: begin
            limit = cfg.turn_ticks;
            phase_next_mode = MODE_STRAIGHT;
         end
      endcase
   end

   always_comb begin
      next_state.mode    = state.mode;
      next_state.pending = pend;
      next_state.phase   = state.phase;
      next_state.budget  = bud;
      case (state.mode)
         MODE_STOP: begin
            next_state.mode    = (pend == CMD_STRAIGHT) ? MODE_STRAIGHT : MODE_STOP;
            next_state.pending = CMD_NONE;
         end
         MODE_STRAIGHT: begin
            next_state.pending = CMD_NONE;
            next_state.phase   = '0;
            case (pend)
               CMD_HALT:     next_state.mode = MODE_STOP;
               CMD_LEFT:     next_state.mode = MODE_TURNL;
               CMD_RIGHT:    next_state.mode = MODE_TURNR;
               CMD_STRAIGHT: next_state.mode = MODE_STRAIGHT;
               default: begin
                  if (middle_range < cfg.stop_dist) begin
                     next_state.mode = MODE_STOP;
                  end else if (left_range < cfg.stop_dist) begin
                     next_state.mode = MODE_AVL1;
                  end else if (left_range > cfg.veer_dist) begin
                     next_state.mode = MODE_AVR1;
                  end else if (bud != '0) begin
                     next_state.budget = bud - 1'b1;
                     next_state.mode   = MODE_STRAIGHT;
                  end else begin
                     next_state.mode = MODE_STOP;
                  end
               end
            endcase
         end
         default: begin
            if (state.phase < limit) begin
               next_state.phase = state.phase + 1'b1;
            end else begin
               next_state.phase = '0;
               next_state.mode  = phase_next_mode;
            end
         end
      endcase
   end

   assign busy = (next_state.pending != CMD_NONE) || (next_state.budget != '0);

endmodule

@@ rtl/core/obstacle_avoid_drive_fsm.sv @@
// Top level of the obstacle avoidance drive controller.
// Each request item is one control tick and produces exactly one response item holding the
// wheel drive, the mode and the busy flag after that tick. The block takes one item per clock
// cycle unless rsp.ready stalls it; the whole state update sits between the state registers
// and the response register, and a new item is taken whenever the response register is empty
// or is being emptied in the same cycle. Configuration writes land in the cycle after csr_we.
module obstacle_avoid_drive_fsm import oad_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   oad_req_if.sink               req,
   oad_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   oad_cfg_type   cfg_ff;
   oad_cfg_type   cfg_in;
   oad_state_type state_ff;
   oad_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          busy;
   logic          req_fire;

   logic signed [DRIVE_W-1:0] left_drive_ff;
   logic signed [DRIVE_W-1:0] right_drive_ff;
   logic [MODE_W-1:0]         mode_ff;
   logic                      busy_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STOP_DIST:   cfg_in.stop_dist   = csr_wdata[DIST_W-1:0];
            CSR_VEER_DIST:   cfg_in.veer_dist   = csr_wdata[DIST_W-1:0];
            CSR_AVOID_TICKS: cfg_in.avoid_ticks = csr_wdata[TICK_W-1:0];
            CSR_TURN_TICKS:  cfg_in.turn_ticks  = csr_wdata[TICK_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   oad_step u_step (
      .state        (state_ff),
      .cfg          (cfg_ff),
      .command      (req.command),
      .load_budget  (req.load_budget),
      .budget_value (req.budget_value),
      .left_range   (req.left_range),
      .middle_range (req.middle_range),
      .next_state   (state_in),
      .busy         (busy)
   );

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_dist   <= STOP_DIST_RESET;
         cfg_ff.veer_dist   <= VEER_DIST_RESET;
         cfg_ff.avoid_ticks <= AVOID_TICKS_RESET;
         cfg_ff.turn_ticks  <= TURN_TICKS_RESET;
         state_ff.mode      <= MODE_STOP;
         state_ff.pending   <= CMD_NONE;
         state_ff.phase     <= '0;
         state_ff.budget    <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_drive_ff  <= oad_left_drive(state_in.mode);
         right_drive_ff <= oad_right_drive(state_in.mode);
         mode_ff        <= state_in.mode;
         busy_ff        <= busy;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.left_drive  = left_drive_ff;
   assign rsp.right_drive = right_drive_ff;
   assign rsp.mode        = mode_ff;
   assign rsp.busy_res    = busy_ff;

`ifndef NO_ASSERTIONS
   a_reset_state: assert property (@(posedge clock)
      reset |=> (state_ff.mode == MODE_STOP) && (state_ff.pending == CMD_NONE) && !rsp_valid_ff)
      else $error("state not cleared by reset");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted item produced no response");

   a_rsp_mode_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (mode_ff == state_ff.mode))
      else $error("response mode differs from state mode");

   a_rsp_busy_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (busy_ff == ((state_ff.pending != CMD_NONE) || (state_ff.budget != '0))))
      else $error("response busy flag differs from state");

   a_phase_only_timed: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != '0) |-> ((state_ff.mode != MODE_STOP) &&
                                  (state_ff.mode != MODE_STRAIGHT)))
      else $error("phase counter running outside a timed mode");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the obstacle avoidance drive controller.
`timescale 1ns / 1ps

module testbench import oad_pkg::*; ();

   localparam int CYCLE_LIMIT   = 250000;
   localparam int DIRECTED_ROWS = 28;

   localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic                load_budget;
      logic [BUDGET_W-1:0] budget_value;
      logic [DIST_W-1:0]   left_range;
      logic [DIST_W-1:0]   middle_range;
   } tick_item_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_duty;
      logic signed [DRIVE_W-1:0] right_duty;
      logic [MODE_W-1:0]         mode;
      logic                      busy;
   } drive_report_type;

   // Register rows carry min and max distance in the range columns and the
   // avoid limit (low half) and turn limit (high half) in the budget column.
   typedef struct packed {
      row_kind_type        kind;
      logic [CMD_W-1:0]    command;
      logic                load_budget;
      logic [BUDGET_W-1:0] budget_value;
      logic [DIST_W-1:0]   left_range;
      logic [DIST_W-1:0]   middle_range;
      logic                typed;
      logic [MODE_W-1:0]   mode;
      logic                busy;
   } plan_row_type;

   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd0, 10'd0, 1'b1, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_LEFT, 1'b0, 32'h0, 10'd1023, 10'd1023, 1'b1, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_RESERVED_HI, 1'b1, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b1, MODE_STOP, 1'b1},
      '{ROW_TICK, CMD_STRAIGHT, 1'b0, 32'h0, 10'd30, 10'd30, 1'b1, MODE_STRAIGHT, 1'b1},
      '{ROW_TICK, CMD_NONE, 1'b1, 32'd2, 10'd20, 10'd20, 1'b1, MODE_STRAIGHT, 1'b1},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd40, 10'd20, 1'b1, MODE_STRAIGHT, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b1, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_STRAIGHT, 1'b1, 32'd5, 10'd1023, 10'd1023, 1'b1, MODE_STRAIGHT, 1'b1},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd20, 10'd19, 1'b1, MODE_STOP, 1'b1},
      '{ROW_CSR, CMD_NONE, 1'b0, 32'h0002_0001, 10'd20, 10'd40, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_STRAIGHT, 1'b0, 32'h0, 10'd0, 10'd0, 1'b1, MODE_STRAIGHT, 1'b1},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd19, 10'd1023, 1'b1, MODE_AVL1, 1'b1},
      '{ROW_TICK, CMD_RIGHT, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_RESERVED_LO, 1'b0, 32'h0, 10'd512, 10'd512, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_LEFT, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_HALT, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_STRAIGHT, 1'b1, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd1023, 10'd1023, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_LEFT, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0},
      '{ROW_TICK, CMD_NONE, 1'b0, 32'h0, 10'd30, 10'd30, 1'b0, MODE_STOP, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  sink_ready = 1'b0;

   oad_req_if req_if ();
   oad_rsp_if rsp_if ();

   assign rsp_if.ready = sink_ready;

   obstacle_avoid_drive_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   logic [DIST_W-1:0]   thr_min     = STOP_DIST_RESET;
   logic [DIST_W-1:0]   thr_max     = VEER_DIST_RESET;
   logic [TICK_W-1:0]   avoid_limit = AVOID_TICKS_RESET;
   logic [TICK_W-1:0]   turn_limit  = TURN_TICKS_RESET;

   logic [MODE_W-1:0]   car_mode    = MODE_STOP;
   logic [CMD_W-1:0]    car_pending = CMD_NONE;
   logic [TICK_W-1:0]   car_phase   = '0;
   logic [BUDGET_W-1:0] car_budget  = '0;

   drive_report_type pending_reports [$];

   int   mismatch_count = 0;
   int   ticks_sent     = 0;
   int   ticks_checked  = 0;
   int   settings_count = 0;
   int   src_gap_pct    = 0;
   int   sink_stall_pct = 0;
   int   stall_left     = 0;
   int   cycle_count    = 0;
   logic [7:0] mode_seen = '0;

   function automatic logic signed [DRIVE_W-1:0] wheel_duty(logic [MODE_W-1:0] m,
                                                          bit right_side);
      logic signed [DRIVE_W-1:0] duty;
      case (m)
         MODE_STOP:             duty = 13'sd0;
         MODE_STRAIGHT:         duty = 13'sd600;
         MODE_AVL1, MODE_AVR2:  duty = right_side ? -13'sd500 : 13'sd2000;
         MODE_AVL2, MODE_AVR1:  duty = right_side ? 13'sd2000 : -13'sd500;
         MODE_TURNL:            duty = right_side ? 13'sd2000 : -13'sd1500;
         default:               duty = right_side ? -13'sd1500 : 13'sd2000;
      endcase
      return duty;
   endfunction

   function automatic drive_report_type report_for(logic [MODE_W-1:0] m, logic busy);
      drive_report_type r;
      r.left_duty  = wheel_duty(m, 1'b0);
      r.right_duty = wheel_duty(m, 1'b1);
      r.mode       = m;
      r.busy       = busy;
      return r;
   endfunction

   function automatic drive_report_type predict_tick(tick_item_type it);
      logic [TICK_W-1:0] limit;
      if (it.command >= CMD_HALT && it.command <= CMD_RIGHT) car_pending = it.command;
      if (it.load_budget) car_budget = it.budget_value;
      case (car_mode)
         MODE_STOP: begin
            car_mode    = (car_pending == CMD_STRAIGHT) ? MODE_STRAIGHT : MODE_STOP;
            car_pending = CMD_NONE;
         end
         MODE_STRAIGHT: begin
            case (car_pending)
               CMD_HALT:     car_mode = MODE_STOP;
               CMD_LEFT:     car_mode = MODE_TURNL;
               CMD_RIGHT:    car_mode = MODE_TURNR;
               CMD_STRAIGHT: car_mode = MODE_STRAIGHT;
               default: begin
                  if (it.middle_range < thr_min) car_mode = MODE_STOP;
                  else if (it.left_range < thr_min) car_mode = MODE_AVL1;
                  else if (it.left_range > thr_max) car_mode = MODE_AVR1;
                  else if (car_budget != 0) begin
                     car_budget = car_budget - 1'b1;
                     car_mode   = MODE_STRAIGHT;
                  end else car_mode = MODE_STOP;
               end
            endcase
            car_pending = CMD_NONE;
            car_phase   = '0;
         end
         default: begin
            limit = (car_mode == MODE_TURNL || car_mode == MODE_TURNR) ? turn_limit
                                                                       : avoid_limit;
            if (car_phase < limit) car_phase = car_phase + 1'b1;
            else begin
               car_phase = '0;
               case (car_mode)
                  MODE_AVL1: car_mode = MODE_AVL2;
                  MODE_AVR1: car_mode = MODE_AVR2;
                  default:   car_mode = MODE_STRAIGHT;
               endcase
            end
         end
      endcase
      return report_for(car_mode, car_pending != CMD_NONE || car_budget != 0);
   endfunction

   function automatic logic [DIST_W-1:0] clamp_range(int v);
      int c;
      c = v;
      if (c < 0) c = 0;
      if (c > 1023) c = 1023;
      return c[DIST_W-1:0];
   endfunction

   function automatic tick_item_type random_tick();
      tick_item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) it.command = CMD_NONE;
      else if (pick < 68) it.command = CMD_STRAIGHT;
      else if (pick < 76) it.command = CMD_HALT;
      else if (pick < 84) it.command = CMD_LEFT;
      else if (pick < 92) it.command = CMD_RIGHT;
      else it.command = CMD_W'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      it.load_budget  = ($urandom_range(0, 99) < 15);
      it.budget_value = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom;
      case ($urandom_range(0, 3))
         0: it.left_range = DIST_W'($urandom_range(0, 1023));
         1: it.left_range = clamp_range(int'(thr_min) + int'($urandom_range(0, 4)) - 2);
         2: it.left_range = clamp_range(int'(thr_max) + int'($urandom_range(0, 4)) - 2);
         default: it.left_range = DIST_W'($urandom_range(thr_min, thr_max));
      endcase
      case ($urandom_range(0, 3))
         0: it.middle_range = DIST_W'($urandom_range(0, 1023));
         1: it.middle_range = clamp_range(int'(thr_min) + int'($urandom_range(0, 4)) - 2);
         default: it.middle_range = DIST_W'($urandom_range(thr_min, 1023));
      endcase
      return it;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      if (mismatch_count < 30)
         $display("Mismatch at response %0d, %s: got %0d, expected %0d",
                  ticks_checked, field, got, want);
      mismatch_count++;
   endtask

   task automatic send_tick(tick_item_type it, bit typed, drive_report_type typed_rep);
      drive_report_type predicted;
      req_if.valid        <= 1'b1;
      req_if.command      <= it.command;
      req_if.load_budget  <= it.load_budget;
      req_if.budget_value <= it.budget_value;
      req_if.left_range   <= it.left_range;
      req_if.middle_range <= it.middle_range;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      predicted = predict_tick(it);
      pending_reports.push_back(typed ? typed_rep : predicted);
      ticks_sent++;
      if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic finish_phase();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_registers(int dmin, int dmax, int avoid, int turn);
      csr_we    <= 1'b1;
      csr_index <= CSR_STOP_DIST;
      csr_wdata <= CSR_DATA_W'(dmin);
      @(posedge clock);
      csr_index <= CSR_VEER_DIST;
      csr_wdata <= CSR_DATA_W'(dmax);
      @(posedge clock);
      csr_index <= CSR_AVOID_TICKS;
      csr_wdata <= CSR_DATA_W'(avoid);
      @(posedge clock);
      csr_index <= CSR_TURN_TICKS;
      csr_wdata <= CSR_DATA_W'(turn);
      @(posedge clock);
      csr_we      <= 1'b0;
      thr_min     = DIST_W'(dmin);
      thr_max     = DIST_W'(dmax);
      avoid_limit = TICK_W'(avoid);
      turn_limit  = TICK_W'(turn);
      settings_count++;
      repeat (2) @(posedge clock);
   endtask

   task automatic run_phase(int dmin, int dmax, int avoid, int turn,
                            int gap_pct, int stall_pct, int count);
      write_registers(dmin, dmax, avoid, turn);
      src_gap_pct    = gap_pct;
      sink_stall_pct = stall_pct;
      repeat (count) send_tick(random_tick(), 1'b0, '0);
      finish_phase();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         sink_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         sink_ready <= 1'b1;
         if ($urandom_range(0, 99) < sink_stall_pct) stall_left <= $urandom_range(1, 15);
      end
   end

   always @(posedge clock) begin
      drive_report_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("item with nothing expected, mode", int'(rsp_if.mode), -1);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_if.left_drive !== want.left_duty)
               report_mismatch("left_drive", int'(rsp_if.left_drive), int'(want.left_duty));
            if (rsp_if.right_drive !== want.right_duty)
               report_mismatch("right_drive", int'(rsp_if.right_drive),
                               int'(want.right_duty));
            if (rsp_if.mode !== want.mode)
               report_mismatch("mode", int'(rsp_if.mode), int'(want.mode));
            if (rsp_if.busy_res !== want.busy)
               report_mismatch("busy_res", int'(rsp_if.busy_res), int'(want.busy));
         end
         if (!$isunknown(rsp_if.mode)) mode_seen[rsp_if.mode] = 1'b1;
         ticks_checked++;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, pending_reports.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin
      tick_item_type it;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_STOP_DIST;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.command      = CMD_NONE;
      req_if.load_budget  = 1'b0;
      req_if.budget_value = '0;
      req_if.left_range   = '0;
      req_if.middle_range = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_gap_pct    = 15;
      sink_stall_pct = 15;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_plan[r].kind == ROW_CSR) begin
            finish_phase();
            write_registers(int'(directed_plan[r].left_range),
                            int'(directed_plan[r].middle_range),
                            int'(directed_plan[r].budget_value[15:0]),
                            int'(directed_plan[r].budget_value[31:16]));
         end else begin
            it.command      = directed_plan[r].command;
            it.load_budget  = directed_plan[r].load_budget;
            it.budget_value = directed_plan[r].budget_value;
            it.left_range   = directed_plan[r].left_range;
            it.middle_range = directed_plan[r].middle_range;
            send_tick(it, directed_plan[r].typed,
                      report_for(directed_plan[r].mode, directed_plan[r].busy));
         end
      end
      finish_phase();

      run_phase(20, 40, 3, 5, 20, 10, 140);
      run_phase(0, 0, 0, 0, 30, 0, 140);
      run_phase(1023, 1023, 65535, 65535, 0, 25, 60);
      run_phase(100, 900, 2, 1, 15, 15, 140);
      run_phase($urandom_range(0, 300), $urandom_range(0, 600), $urandom_range(0, 6),
                $urandom_range(0, 6), 10, 20, 140);
      run_phase(30, 10, 4, 4, 20, 20, 140);
      run_phase(20, 40, 1, 2, 0, 0, 140);

      $display("Sent %0d drive ticks and checked %0d responses over %0d register settings.",
               ticks_sent, ticks_checked, settings_count);
      $display("Thresholds and phase limits ran at both ends; modes reached (bit per mode): %b",
               mode_seen);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/oad_pkg.sv
rtl/core/oad_if.sv
rtl/core/oad_step.sv
rtl/core/obstacle_avoid_drive_fsm.sv
verif/testbench.sv
